// File: hdl/gwm_pkg.sv
// Shared constants, state codes and handshake structs of the wildcard matcher.
package gwm_pkg;

    // Default store depth in characters.
    localparam int MAX_LEN_DEF = 64;

    // Width of one character.
    localparam int CHAR_W = 8;

    // Pattern byte that matches any run of text characters.
    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

    // Codes of the which_string field.
    localparam logic WHICH_PATTERN = 1'b0;
    localparam logic WHICH_TEXT    = 1'b1;

    // States of the match sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_STEP,
        ST_DONE
    } gwm_state_t;

    // Start command from the loader to the match sequencer.
    typedef struct packed {
        logic go;
        logic too_long;
    } gwm_cmd_t;

    // Result from the match sequencer to the output register.
    typedef struct packed {
        logic valid;
        logic matched;
        logic too_long;
    } gwm_res_t;

endpackage

// File: hdl/gwm_ram.sv
// Character store: one write port and one read port with registered read data.
module gwm_ram #(
    parameter int DEPTH = gwm_pkg::MAX_LEN_DEF,
    parameter int AW    = $clog2(gwm_pkg::MAX_LEN_DEF)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [gwm_pkg::CHAR_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [gwm_pkg::CHAR_W-1:0] rdata
);
    import gwm_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/gwm_engine.sv
// Match sequencer: greedy star match with backtracking over the two stores.
module gwm_engine #(
    parameter int AW      = $clog2(gwm_pkg::MAX_LEN_DEF),
    parameter int LW      = $clog2(gwm_pkg::MAX_LEN_DEF + 2)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gwm_pkg::gwm_cmd_t          cmd,
    input  logic [LW-1:0]              plen,
    input  logic [LW-1:0]              tlen,
    output logic [AW-1:0]              p_raddr,
    output logic [AW-1:0]              t_raddr,
    input  logic [gwm_pkg::CHAR_W-1:0] p_rdata,
    input  logic [gwm_pkg::CHAR_W-1:0] t_rdata,
    output gwm_pkg::gwm_res_t          res,
    input  logic                       res_take,
    output logic                       busy
);
    import gwm_pkg::*;

    gwm_state_t state_reg, state_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] tmark_reg, tmark_next;
    logic [LW-1:0] pmark_reg, pmark_next;
    logic          have_reg, have_next;
    logic          matched_reg, matched_next;
    logic          tl_reg, tl_next;

    logic p_ok;
    logic p_star;
    logic t_act;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Match indexes and result.
    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        tmark_reg   <= tmark_next;
        pmark_reg   <= pmark_next;
        have_reg    <= have_next;
        matched_reg <= matched_next;
        tl_reg      <= tl_next;
    end

    assign p_ok   = (j_reg < plen);
    assign p_star = p_ok && (p_rdata == STAR_CHAR);
    assign t_act  = (i_reg < tlen);

    // One match step per cycle; the read for the next step is issued at once.
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        tmark_next   = tmark_reg;
        pmark_next   = pmark_reg;
        have_next    = have_reg;
        matched_next = matched_reg;
        tl_next      = tl_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.go)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    tmark_next = '0;
                    pmark_next = '0;
                    have_next  = 1'b0;
                    if (cmd.too_long)
                    begin
                        matched_next = 1'b0;
                        tl_next      = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        tl_next    = 1'b0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (t_act)
                begin
                    priority if (p_star)
                    begin
                        tmark_next = i_reg;
                        pmark_next = j_reg;
                        have_next  = 1'b1;
                        j_next     = j_reg + 1'b1;
                    end
                    else if (p_ok && (t_rdata == p_rdata))
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = j_reg + 1'b1;
                    end
                    else if (have_reg)
                    begin
                        tmark_next = tmark_reg + 1'b1;
                        i_next     = tmark_reg + 1'b1;
                        j_next     = pmark_reg + 1'b1;
                    end
                    else
                    begin
                        matched_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
                else
                begin
                    // Text used up: only trailing stars may remain.
                    if (p_star)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        matched_next = (j_reg == plen);
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign p_raddr      = j_next[AW-1:0];
    assign t_raddr      = i_next[AW-1:0];
    assign res.valid    = (state_reg == ST_DONE);
    assign res.matched  = matched_reg;
    assign res.too_long = tl_reg;
    assign busy         = (state_reg != ST_IDLE);

    // The pattern index never passes the pattern length.
    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (j_reg <= plen))
        else $error("pattern index beyond pattern length");

    // The text index never passes the text length.
    a_i_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (i_reg <= tlen))
        else $error("text index beyond text length");

    // The backtrack mark never lies ahead of the text index.
    a_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && have_reg) |-> (tmark_reg <= i_reg))
        else $error("backtrack mark ahead of text index");

    // A result stays until the output register takes it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res_take) |=> (res.valid && $stable(res.matched)
            && $stable(res.too_long)))
        else $error("result dropped before it was taken");

endmodule

// File: hdl/glob_wildcard_matcher.sv
// Glob wildcard matcher top level: string loader, two stores, sequencer, output register.
//
// Usage: requests arrive on the in channel (in_valid/in_ready), one character
// each, tagged by which_string as pattern or text, with end_of_string on the
// last one; string_empty marks a request that carries no character and ends
// the string. The pattern stays loaded for any number of texts. Each text
// that ends gives one result on the out channel (out_valid/out_ready):
// matched, and too_long when either string passed MAX_LEN characters.
// Loading takes one cycle per request while in_ready is high. After a text
// ends, the sequencer reads both stores in its fetch state, then makes one
// match step per cycle (the pattern and text stores are read together for
// each step), then holds the result in its done state until it is handed
// over; the steps grow with text length times pattern length when stars
// backtrack. A too-long text skips the walk. in_ready is low while busy.
// A finished result sits in the output register while new requests are
// taken; if the receiver stalls, a second result waits in the sequencer and
// in_ready stays low until the first is taken. Reset clears both lengths,
// the overflow flag and the output, and expects a new string next.
module glob_wildcard_matcher #(
    parameter int MAX_LEN = gwm_pkg::MAX_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       which_string,
    input  logic [gwm_pkg::CHAR_W-1:0] char_value,
    input  logic                       end_of_string,
    input  logic                       string_empty,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       matched,
    output logic                       too_long
);
    import gwm_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 2);
    localparam logic [LW-1:0] MAX_LEN_L  = LW'(MAX_LEN);
    localparam logic [LW-1:0] OVER_LEN_L = LW'(MAX_LEN + 1);

    logic [LW-1:0] plen_reg, plen_next;
    logic [LW-1:0] tlen_reg, tlen_next;
    logic          ovf_reg, ovf_next;
    logic          loading_reg, loading_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_matched_reg, out_matched_next;
    logic          out_tl_reg, out_tl_next;

    logic          accept;
    logic          is_text;
    logic          str_end;
    logic [LW-1:0] plen_base;
    logic [LW-1:0] tlen_base;
    logic          p_we;
    logic          t_we;
    logic [AW-1:0] p_waddr;
    logic [AW-1:0] t_waddr;
    logic [AW-1:0] p_raddr;
    logic [AW-1:0] t_raddr;
    logic [CHAR_W-1:0] p_rdata;
    logic [CHAR_W-1:0] t_rdata;
    logic          busy;
    logic          res_take;
    gwm_cmd_t      cmd;
    gwm_res_t      res;

    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;
    assign is_text  = (which_string == WHICH_TEXT);
    assign str_end  = end_of_string || string_empty;

    // Loader: start a new string, append a character, track overflow.
    always_comb
    begin
        plen_base = (loading_reg && !is_text) ? '0 : plen_reg;
        tlen_base = (loading_reg && is_text) ? '0 : tlen_reg;
        plen_next    = plen_reg;
        tlen_next    = tlen_reg;
        ovf_next     = ovf_reg;
        loading_next = loading_reg;
        p_we         = 1'b0;
        t_we         = 1'b0;
        p_waddr      = plen_base[AW-1:0];
        t_waddr      = tlen_base[AW-1:0];

        if (accept)
        begin
            loading_next = str_end;
            if (is_text)
            begin
                tlen_next = tlen_base;
                if (!string_empty)
                begin
                    if (tlen_base < MAX_LEN_L)
                    begin
                        t_we      = 1'b1;
                        tlen_next = tlen_base + 1'b1;
                    end
                    else
                    begin
                        tlen_next = OVER_LEN_L;
                    end
                end
            end
            else
            begin
                plen_next = plen_base;
                if (loading_reg)
                begin
                    ovf_next = 1'b0;
                end
                if (!string_empty)
                begin
                    if (plen_base < MAX_LEN_L)
                    begin
                        p_we      = 1'b1;
                        plen_next = plen_base + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
        end
    end

    // Start the sequencer when a text ends.
    assign cmd.go       = accept && is_text && str_end;
    assign cmd.too_long = ovf_reg || (tlen_next > MAX_LEN_L);

    // Output register takes the result when it is empty or being drained.
    assign res_take = res.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_matched_next = out_matched_reg;
        out_tl_next      = out_tl_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next   = 1'b1;
            out_matched_next = res.matched;
            out_tl_next      = res.too_long;
        end
    end

    // Loader and output control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            tlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            loading_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            tlen_reg      <= tlen_next;
            ovf_reg       <= ovf_next;
            loading_reg   <= loading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_matched_reg <= out_matched_next;
        out_tl_reg      <= out_tl_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = out_matched_reg;
    assign too_long  = out_tl_reg;

    // Pattern store.
    gwm_ram #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_pat_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (char_value),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // Text store.
    gwm_ram #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_txt_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (char_value),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // Match sequencer.
    gwm_engine #(
        .AW      (AW),
        .LW      (LW)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .plen     (plen_reg),
        .tlen     (tlen_reg),
        .p_raddr  (p_raddr),
        .t_raddr  (t_raddr),
        .p_rdata  (p_rdata),
        .t_rdata  (t_rdata),
        .res      (res),
        .res_take (res_take),
        .busy     (busy)
    );

endmodule

// File: sim/tb_glob_wildcard_matcher.sv
// Self-checking testbench of the glob wildcard matcher: directed table, random strings, stalls.
`timescale 1ns / 1ps

module tb_glob_wildcard_matcher;

    import gwm_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam longint TIMEOUT_NS = 100_000_000;
    localparam int DIRECTED_ROWS = 23;

    // One verdict of the matcher, as it leaves the out channel.
    typedef struct packed {
        logic matched;
        logic too_long;
    } verdict_t;

    // One request of the directed table, with an optional hand-written verdict.
    typedef struct packed {
        logic              which;
        logic [CHAR_W-1:0] ch;
        logic              eos;
        logic              empty;
        logic              typed;
        logic              exp_matched;
        logic              exp_too_long;
    } stim_row_t;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    // Directed requests. Hand-written verdicts: empty pattern against empty and
    // non-empty texts, and two stars against an empty text.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{WHICH_TEXT,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{WHICH_TEXT,    "a",   1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
        '{WHICH_PATTERN, "*",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    8'h55, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_PATTERN, "a",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_PATTERN, "*",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_PATTERN, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    "a",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    "q",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    "q",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    "a",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_PATTERN, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    "x",   1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
        '{WHICH_TEXT,    "a",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_PATTERN, "*",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    "b",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_PATTERN, "*",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_PATTERN, "*",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{WHICH_TEXT,    8'h33, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              which_string;
    logic [CHAR_W-1:0] char_value;
    logic              end_of_string;
    logic              string_empty;
    logic              out_valid;
    logic              out_ready;
    logic              matched;
    logic              too_long;

    // Predictor state: its own copy of both stores and the loader flags.
    logic [CHAR_W-1:0] pattern_chars [MAX_LEN];
    logic [CHAR_W-1:0] text_chars [MAX_LEN];
    bit [6:0]          pattern_count;
    bit [6:0]          text_count;
    bit                pattern_overflow;
    bit                at_string_start;

    verdict_t          pending_verdicts[$];
    verdict_t          head_verdict;
    int                mismatches;
    int                items_sent;
    bit                calm;
    bit                hold_request;

    glob_wildcard_matcher #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .which_string(which_string),
        .char_value(char_value),
        .end_of_string(end_of_string),
        .string_empty(string_empty),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .matched(matched),
        .too_long(too_long)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("glob_wildcard_matcher: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Greedy star match with backtracking to the most recent star.
    function automatic bit glob_matches();
        int  pi = 0;
        int  ti = 0;
        int  tmark = 0;
        int  pmark = 0;
        bit  star_seen = 1'b0;
        if (pattern_count == 0)
            return text_count == 0;
        while (ti < text_count)
        begin
            if (pi < pattern_count && pattern_chars[pi] == STAR_CHAR)
            begin
                tmark = ti;
                pmark = pi;
                star_seen = 1'b1;
                pi++;
            end
            else if (pi < pattern_count && text_chars[ti] == pattern_chars[pi])
            begin
                ti++;
                pi++;
            end
            else if (star_seen)
            begin
                tmark++;
                ti = tmark;
                pi = pmark + 1;
            end
            else
                return 1'b0;
        end
        while (pi < pattern_count && pattern_chars[pi] == STAR_CHAR)
            pi++;
        return pi == pattern_count;
    endfunction

    // Load one request into the predictor and say whether it ends a text.
    task automatic load_and_judge(input bit which, input logic [CHAR_W-1:0] ch,
                                  input bit eos, input bit empty,
                                  output bit gives, output verdict_t v);
        bit over;
        gives = 1'b0;
        v = '0;
        if (at_string_start)
        begin
            if (which == WHICH_TEXT)
                text_count = '0;
            else
            begin
                pattern_count = '0;
                pattern_overflow = 1'b0;
            end
        end
        at_string_start = 1'b0;

        // Append the character, saturating the text length past the store.
        if (!empty)
        begin
            if (which == WHICH_TEXT)
            begin
                if (text_count < MAX_LEN)
                begin
                    text_chars[text_count] = ch;
                    text_count++;
                end
                else
                    text_count = 7'(MAX_LEN + 1);
            end
            else
            begin
                if (pattern_count < MAX_LEN)
                begin
                    pattern_chars[pattern_count] = ch;
                    pattern_count++;
                end
                else
                    pattern_overflow = 1'b1;
            end
        end

        // An empty request ends the string whatever end_of_string says.
        if (eos || empty)
        begin
            at_string_start = 1'b1;
            if (which == WHICH_TEXT)
            begin
                over = pattern_overflow || (text_count > MAX_LEN);
                gives = 1'b1;
                v.too_long = over;
                v.matched = over ? 1'b0 : glob_matches();
            end
        end
    endtask

    // Mostly short gaps, a few long ones, none in calm stretches.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request, wait until it is taken, and predict its verdict.
    task automatic send_request(input bit which, input logic [CHAR_W-1:0] ch,
                                input bit eos, input bit empty,
                                input bit typed = 1'b0, input verdict_t typed_v = '0);
        int       gap;
        bit       gives;
        verdict_t v;
        gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        which_string <= which;
        char_value <= ch;
        end_of_string <= eos;
        string_empty <= empty;
        // Ready seen at the falling edge holds through the next rising edge.
        @(negedge clk);
        while (in_ready !== 1'b1)
            @(negedge clk);
        load_and_judge(which, ch, eos, empty, gives, v);
        if (gives)
            pending_verdicts.push_back(typed ? typed_v : v);
        items_sent++;
        @(posedge clk);
    endtask

    // Drop valid and wait until every predicted verdict has come out.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_length();
        int r;
        int longs [4] = '{MAX_LEN - 1, MAX_LEN, MAX_LEN + 1, MAX_LEN + 2};
        r = $urandom_range(0, 99);
        if (r < 3)
            return longs[$urandom_range(0, 3)];
        if (r < 10)
            return 0;
        return $urandom_range(1, 8);
    endfunction

    // Small alphabet so that matches happen; stars only where asked.
    function automatic logic [CHAR_W-1:0] pick_char(input bit with_star);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return "a";
        if (r < 60)
            return "b";
        if (r < 72 && with_star)
            return STAR_CHAR;
        if (r < 80)
            return "c";
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic char_q_t random_string(input bit with_star);
        char_q_t s;
        int      len;
        len = pick_length();
        for (int k = 0; k < len; k++)
            s.push_back(pick_char(with_star));
        return s;
    endfunction

    // A text built from the pattern: stars expand to short runs, now and then a typo.
    function automatic char_q_t text_for(input char_q_t pat);
        char_q_t s;
        int      runs;
        foreach (pat[k])
        begin
            if (pat[k] == STAR_CHAR)
            begin
                runs = $urandom_range(0, 3);
                repeat (runs) s.push_back(pick_char(1'b0));
            end
            else
                s.push_back(pat[k]);
        end
        if (s.size() != 0 && $urandom_range(0, 99) < 15)
            s[$urandom_range(0, s.size() - 1)] = pick_char(1'b0);
        return s;
    endfunction

    // Send a whole string; sometimes an empty request closes it instead of end_of_string.
    task automatic send_string(input bit which, input char_q_t s);
        bit close_empty;
        if (s.size() == 0)
            send_request(which, CHAR_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'b1);
        else
        begin
            close_empty = ($urandom_range(0, 99) < 15);
            foreach (s[k])
                send_request(which, s[k], (k == s.size() - 1) && !close_empty, 1'b0);
            if (close_empty)
                send_request(which, CHAR_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    // Result checker: compares each taken verdict with the oldest prediction.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("verdict matched=%b too_long=%b with none pending",
                                          matched, too_long));
            else
            begin
                head_verdict = pending_verdicts.pop_front();
                if (matched !== head_verdict.matched)
                    report_mismatch($sformatf("matched: expected %b got %b",
                                              head_verdict.matched, matched));
                if (too_long !== head_verdict.too_long)
                    report_mismatch($sformatf("too_long: expected %b got %b",
                                              head_verdict.too_long, too_long));
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold when asked.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_length()) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Sender: reset, directed table, random strings, then drain and verdict.
    initial
    begin
        int       round;
        int       kind;
        int       texts;
        int       cut;
        char_q_t  pat;
        char_q_t  txt;
        verdict_t row_v;

        round = 0;
        mismatches = 0;
        items_sent = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        pattern_count = '0;
        text_count = '0;
        pattern_overflow = 1'b0;
        at_string_start = 1'b1;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        which_string <= WHICH_PATTERN;
        char_value <= '0;
        end_of_string <= 1'b0;
        string_empty <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests.
        foreach (DIRECTED[k])
        begin
            row_v.matched = DIRECTED[k].exp_matched;
            row_v.too_long = DIRECTED[k].exp_too_long;
            send_request(DIRECTED[k].which, DIRECTED[k].ch, DIRECTED[k].eos,
                         DIRECTED[k].empty, DIRECTED[k].typed, row_v);
        end
        wait_for_results();

        // Random rounds: mostly a pattern followed by several texts.
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            round++;
            calm = (round % 12 == 11);
            kind = $urandom_range(0, 99);

            if (round == 30 || round == 120)
            begin
                // Fill the block while the receiver holds off.
                hold_request = 1'b1;
                repeat (8)
                begin
                    txt.delete();
                    repeat ($urandom_range(0, 2)) txt.push_back(pick_char(1'b0));
                    send_string(WHICH_TEXT, txt);
                end
            end
            else if (kind < 8)
            begin
                // Noise: fully random requests.
                repeat ($urandom_range(1, 6))
                    send_request(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
            end
            else if (kind < 16)
            begin
                // A pattern request cuts into a text in progress.
                txt = text_for(pat);
                cut = $urandom_range(1, 3);
                for (int k = 0; k < cut; k++)
                    send_request(WHICH_TEXT, (k < txt.size()) ? txt[k] : pick_char(1'b0),
                                 1'b0, 1'b0);
                send_request(WHICH_PATTERN, pick_char(1'b1), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 4) == 0);
                send_string(WHICH_TEXT, random_string(1'b0));
            end
            else
            begin
                // Well formed: a new pattern, then texts built from it or random.
                pat = random_string(1'b1);
                send_string(WHICH_PATTERN, pat);
                texts = $urandom_range(1, 5);
                repeat (texts)
                begin
                    if ($urandom_range(0, 99) < 60)
                        send_string(WHICH_TEXT, text_for(pat));
                    else
                        send_string(WHICH_TEXT, random_string(1'b0));
                end
            end

            if (round % 17 == 0)
                wait_for_results();
        end

        // Drain, then let any trailing pattern request settle.
        calm = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("glob_wildcard_matcher: match");
        else
            $display("glob_wildcard_matcher: mismatch");
        $finish;
    end

endmodule
